// ----- sv/cpt_pkg.sv -----
// Package of the clip playhead timer: widths, register indexes and constants.
package cpt_pkg;

	localparam int unsigned MARKER_COUNT = 4;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned STEP_W   = 16;
	localparam int unsigned RATE_W   = 16;
	localparam int unsigned PHASE_W  = 17;
	localparam int unsigned HITS_W   = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Movement after the Q8.8 shift, signed
	localparam int unsigned MOVE_W = 24;
	// Position sum before wrap or clamp, signed
	localparam int unsigned POS_W  = 34;
	// Serial unit operand width
	localparam int unsigned REM_W  = 33;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_CLIP_LENGTH   = 3'd0;
	localparam cfg_idx_t REG_RATE_GAIN     = 3'd1;
	localparam cfg_idx_t REG_LOOP_ENABLE   = 3'd2;
	localparam cfg_idx_t REG_MARKER_ENABLE = 3'd3;
	localparam cfg_idx_t REG_MARKER_TIME_A = 3'd4;
	localparam cfg_idx_t REG_MARKER_TIME_B = 3'd5;
	localparam cfg_idx_t REG_MARKER_TIME_C = 3'd6;
	localparam cfg_idx_t REG_MARKER_TIME_D = 3'd7;

	localparam logic [TIME_W-1:0]  CLIP_LENGTH_RST = 32'd65536;
	localparam logic [RATE_W-1:0]  RATE_GAIN_RST   = 16'd256;
	localparam logic [PHASE_W-1:0] PHASE_ONE       = 17'd65536;

endpackage

// ----- sv/cpt_if.sv -----
// Valid/ready channel interfaces for tick words and result words.
interface cpt_tick_if
	import cpt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] time_step;
	logic              advance;

	modport source (output valid, output time_step, output advance, input ready);
	modport sink   (input valid, input time_step, input advance, output ready);
endinterface

interface cpt_result_if
	import cpt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [TIME_W-1:0]  head_position;
	logic [PHASE_W-1:0] phase;
	logic [HITS_W-1:0]  marker_hits;

	modport source (output valid, output head_position, output phase, output marker_hits,
		input ready);
	modport sink   (input valid, input head_position, input phase, input marker_hits,
		output ready);
endinterface

// ----- sv/clip_playhead_timer_unit.sv -----
// Clip playhead timer: moves, wraps or clamps the playhead and reports phase and marker hits.
//
// Usage notes:
//  - tick (sink): one word per frame, time_step in 1/65536 s and advance flag.
//  - result (source): one word per tick: head_position, phase (Q1.16, 65536 = 1.0)
//    and marker_hits.
//  - cfg_we/cfg_index/cfg_data: plain register writes, index as listed in cpt_pkg;
//    write only while the block is idle.
//  - One tick word at a time. tick.ready is high only in IDLE. An accepted tick runs
//    through MUL and SUM, then MOD and FIX when the new position leaves
//    [0, clip_length) in loop mode, then DIV and OUT; with an empty clip SUM goes
//    straight to OUT. The work is done by the single 33-bit compare/subtract unit:
//    a bit-serial modulo of 33 steps followed by a 17-step phase division.
//  - A new tick word is taken only after the previous one has left OUT.
//  - The result word sits in an output register; a new tick is accepted while it
//    waits, and that tick's work stalls at the end until the register is free.
//  - Reset: registers back to their defaults (length 1 s, rate 1.0, loop on,
//    markers off), playhead at 0, no result pending.
module clip_playhead_timer_unit
	import cpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	cpt_tick_if.sink              tick,
	cpt_result_if.source          result,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_SUM  = 7'b0000100,
		S_MOD  = 7'b0001000,
		S_FIX  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [TIME_W-1:0]       clip_length_q;
	logic signed [RATE_W-1:0] rate_gain_q;
	logic                    loop_enable_q;
	logic [MARKER_COUNT-1:0] marker_enable_q;
	logic [TIME_W-1:0]       marker_time_q [MARKER_COUNT];

	// playhead and per-tick working registers
	logic [TIME_W-1:0]  playhead_q;
	logic [TIME_W-1:0]  prev_q;
	logic [STEP_W-1:0]  step_q;
	logic               adv_q;
	logic signed [MOVE_W-1:0] move_q;
	logic [TIME_W-1:0]  now_q;
	logic               zlen_q;
	logic               neg_q;
	logic [REM_W-1:0]   abs_q;
	logic [REM_W-1:0]   rem_q;
	logic [PHASE_W-1:0] quo_q;
	logic [5:0]         cnt_q;

	// result register
	logic               out_valid_q;
	logic [TIME_W-1:0]  out_pos_q;
	logic [PHASE_W-1:0] out_phase_q;
	logic [HITS_W-1:0]  out_hits_q;

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_length_q   <= CLIP_LENGTH_RST;
			rate_gain_q     <= RATE_GAIN_RST;
			loop_enable_q   <= 1'b1;
			marker_enable_q <= '0;
			for (int k = 0; k < MARKER_COUNT; k++) marker_time_q[k] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLIP_LENGTH:   clip_length_q   <= cfg_data[TIME_W-1:0];
				REG_RATE_GAIN:     rate_gain_q     <= cfg_data[RATE_W-1:0];
				REG_LOOP_ENABLE:   loop_enable_q   <= cfg_data[0];
				REG_MARKER_ENABLE: marker_enable_q <= cfg_data[MARKER_COUNT-1:0];
				REG_MARKER_TIME_A, REG_MARKER_TIME_B,
				REG_MARKER_TIME_C, REG_MARKER_TIME_D: begin
					// marker slots beyond MARKER_COUNT are dropped
					for (int k = 0; k < MARKER_COUNT; k++)
						if (cfg_index == cfg_idx_t'(32'(REG_MARKER_TIME_A) + k))
							marker_time_q[k] <= cfg_data[TIME_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	// movement: step * rate in Q8.8, floor by arithmetic shift
	logic signed [STEP_W+RATE_W:0] prod;
	assign prod = $signed({1'b0, step_q}) * rate_gain_q;

	// exact position sum, signed
	logic signed [POS_W-1:0] pos;
	assign pos = $signed({2'b00, prev_q})
		+ (adv_q ? POS_W'(move_q) : POS_W'(0));

	logic [POS_W-1:0] dur_ext;
	assign dur_ext = {2'b00, clip_length_q};

	logic pos_neg, pos_in_range, pos_over_dur;
	assign pos_neg      = pos[POS_W-1];
	assign pos_in_range = !pos_neg && (pos < $signed(dur_ext));
	assign pos_over_dur = !pos_neg && (pos > $signed(dur_ext));

	logic [TIME_W-1:0] sat_pos;
	always_comb begin
		if (pos_neg)                     sat_pos = '0;
		else if (pos[POS_W-2:TIME_W] != '0) sat_pos = '1;
		else                             sat_pos = pos[TIME_W-1:0];
	end

	logic [TIME_W-1:0] clamp_pos;
	always_comb begin
		if (pos_neg)           clamp_pos = '0;
		else if (pos_over_dur) clamp_pos = clip_length_q;
		else                   clamp_pos = pos[TIME_W-1:0];
	end

	logic [REM_W-1:0] pos_abs;
	assign pos_abs = pos_neg ? REM_W'(-pos) : pos[REM_W-1:0];

	// shared compare/subtract unit, serves both modulo and phase division
	logic [REM_W-1:0] unit_a;
	logic [REM_W:0]   unit_diff;
	logic             unit_ge;
	always_comb begin
		if (state_q == S_MOD)    unit_a = {rem_q[TIME_W-1:0], abs_q[REM_W-1]};
		else if (cnt_q == '0)    unit_a = rem_q;   // first quotient bit, no shift
		else                     unit_a = {rem_q[TIME_W-1:0], 1'b0};
	end
	assign unit_diff = {1'b0, unit_a} - {2'b00, clip_length_q};
	assign unit_ge   = !unit_diff[REM_W];

	// modulo correction for a negative sum
	logic [TIME_W-1:0] fix_pos;
	assign fix_pos = (neg_q && rem_q[TIME_W-1:0] != '0)
		? clip_length_q - rem_q[TIME_W-1:0] : rem_q[TIME_W-1:0];

	// marker crossing between prev and now
	logic [HITS_W-1:0] hits_c;
	always_comb begin
		hits_c = '0;
		for (int k = 0; k < MARKER_COUNT; k++) begin
			if (now_q >= prev_q)
				hits_c[k] = marker_enable_q[k]
					&& (marker_time_q[k] > prev_q) && (marker_time_q[k] <= now_q);
			else
				hits_c[k] = marker_enable_q[k]
					&& ((marker_time_q[k] > prev_q) || (marker_time_q[k] <= now_q));
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || result.ready;

	// result register loads this cycle
	logic out_load;
	assign out_load = (state_q == S_OUT) && out_free;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			playhead_q  <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_load)                         out_valid_q <= 1'b1;
			else if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						step_q  <= tick.time_step;
						adv_q   <= tick.advance;
						prev_q  <= playhead_q;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					move_q  <= prod[MOVE_W+7:8];
					state_q <= S_SUM;
				end
				S_SUM: begin
					zlen_q <= (clip_length_q == '0);
					cnt_q  <= '0;
					if (clip_length_q == '0) begin
						now_q   <= sat_pos;
						state_q <= S_OUT;
					end else if (loop_enable_q && !pos_in_range) begin
						neg_q   <= pos_neg;
						abs_q   <= pos_abs;
						rem_q   <= '0;
						state_q <= S_MOD;
					end else begin
						now_q   <= loop_enable_q ? pos[TIME_W-1:0] : clamp_pos;
						rem_q   <= {1'b0, loop_enable_q ? pos[TIME_W-1:0] : clamp_pos};
						state_q <= S_DIV;
					end
				end
				S_MOD: begin
					rem_q <= unit_ge ? unit_diff[REM_W-1:0] : unit_a;
					abs_q <= {abs_q[REM_W-2:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(REM_W-1)) state_q <= S_FIX;
				end
				S_FIX: begin
					now_q   <= fix_pos;
					rem_q   <= {1'b0, fix_pos};
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= unit_ge ? unit_diff[REM_W-1:0] : unit_a;
					quo_q <= {quo_q[PHASE_W-2:0], unit_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(PHASE_W-1)) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_pos_q   <= now_q;
						out_phase_q <= zlen_q ? PHASE_ONE : quo_q;
						out_hits_q  <= (adv_q && !zlen_q) ? hits_c : '0;
						playhead_q  <= now_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tick.ready           = (state_q == S_IDLE);
	assign result.valid         = out_valid_q;
	assign result.head_position = out_pos_q;
	assign result.phase         = out_phase_q;
	assign result.marker_hits   = out_hits_q;

endmodule
